// ----- rtl/srht_pkg.sv -----
// Shared constants and types for the segment versus rectangle hit test.
package srht_pkg;

    // default coordinate width
    localparam int unsigned COORD_BITS_DEF = 16;

    // configuration register index width
    localparam int unsigned CFG_IDX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT   = 2'd0,
        CFG_TOP    = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

endpackage

// ----- rtl/segment_rect_hit_test.sv -----
// Top level: segment versus half-open rectangle hit test, fully pipelined.
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+---------------------------
//  request | i_start_x, i_start_y, i_end_x, i_end_y       | i_start high, o_busy low
//  result  | o_hit                                        | o_valid strobe, one cycle
//  config  | i_cfg_idx, i_cfg_data                        | i_cfg_we, no wait
//
// A request is taken every cycle; o_busy stays low.
// The stages are the input stage, the multiply stage, one divider cell per
// quotient bit (2*COORD_BITS+3 cells), and the output compare stage.
// Reset clears the rectangle and every valid flag in the pipeline.
// The receiver cannot stall; a result is shown for exactly one cycle.
module segment_rect_hit_test #(
    parameter int unsigned COORD_BITS = srht_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [COORD_BITS-1:0]  i_start_x,
    input  logic signed [COORD_BITS-1:0]  i_start_y,
    input  logic signed [COORD_BITS-1:0]  i_end_x,
    input  logic signed [COORD_BITS-1:0]  i_end_y,
    output logic                          o_valid,
    output logic                          o_hit,
    input  logic                          i_cfg_we,
    input  logic [srht_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]         i_cfg_data
);
    import srht_pkg::*;

    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned NW = 2 * CB + 3;   // product magnitude
    localparam int unsigned DW = CB + 1;       // divisor magnitude
    localparam int unsigned SW = 4 + 2 * CB;   // side data through the cells
    localparam int unsigned QW = NW + 2;       // signed intersection coordinate

    // configuration registers
    logic signed [CB-1:0] r_left, r_top;
    logic [CB-2:0]        r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LEFT:   r_left   <= i_cfg_data;
                CFG_TOP:    r_top    <= i_cfg_data;
                CFG_WIDTH:  r_width  <= i_cfg_data[CB-2:0];
                CFG_HEIGHT: r_height <= i_cfg_data[CB-2:0];
                default:    ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // rectangle bounds, one bit wider than a coordinate
    logic signed [CB:0] left_e, top_e, right_e, bot_e;
    assign left_e  = {r_left[CB-1], r_left};
    assign top_e   = {r_top[CB-1], r_top};
    assign right_e = left_e + $signed({2'b00, r_width});
    assign bot_e   = top_e + $signed({2'b00, r_height});

    // stage A: early decisions and differences
    logic signed [CB:0]   x1e, y1e, x2e, y2e, ex, ey, dxv, dyv;
    logic signed [CB+1:0] axv, ayv;
    logic in1, in2, side_out, axis, a_dec, a_hit;

    always_comb begin
        x1e = {i_start_x[CB-1], i_start_x};
        y1e = {i_start_y[CB-1], i_start_y};
        x2e = {i_end_x[CB-1], i_end_x};
        y2e = {i_end_y[CB-1], i_end_y};
        in1 = (x1e >= left_e) && (x1e < right_e) && (y1e >= top_e) && (y1e < bot_e);
        in2 = (x2e >= left_e) && (x2e < right_e) && (y2e >= top_e) && (y2e < bot_e);
        side_out = ((x1e < left_e) && (x2e < left_e)) || ((y1e < top_e) && (y2e < top_e))
                || ((x1e >= right_e) && (x2e >= right_e))
                || ((y1e >= bot_e) && (y2e >= bot_e));
        axis  = (x1e == x2e) || (y1e == y2e);
        a_dec = in1 || in2 || side_out || axis;
        a_hit = in1 || in2 || (!side_out && axis);
        ex    = (x1e < left_e) ? left_e : right_e;
        ey    = (y1e < top_e) ? top_e : bot_e;
        dxv   = x2e - x1e;
        dyv   = y2e - y1e;
        axv   = {ex[CB], ex} - {x1e[CB], x1e};
        ayv   = {ey[CB], ey} - {y1e[CB], y1e};
    end

    logic                 r_a_valid, r_a_dec, r_a_hit;
    logic signed [CB-1:0] r_a_x1, r_a_y1;
    logic signed [CB:0]   r_a_dx, r_a_dy;
    logic signed [CB+1:0] r_a_ax, r_a_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_dec <= a_dec;
        r_a_hit <= a_hit;
        r_a_x1  <= i_start_x;
        r_a_y1  <= i_start_y;
        r_a_dx  <= dxv;
        r_a_dy  <= dyv;
        r_a_ax  <= axv;
        r_a_ay  <= ayv;
    end

    // stage B: products, magnitudes and quotient signs
    logic signed [NW-1:0] prod_y, prod_x;
    logic [NW-1:0]        mag_py, mag_px;
    logic [DW-1:0]        mag_dx, mag_dy;

    always_comb begin
        prod_y = r_a_dy * r_a_ax;
        prod_x = r_a_dx * r_a_ay;
        mag_py = prod_y[NW-1] ? NW'(-prod_y) : NW'(prod_y);
        mag_px = prod_x[NW-1] ? NW'(-prod_x) : NW'(prod_x);
        mag_dx = r_a_dx[CB] ? DW'(-r_a_dx) : DW'(r_a_dx);
        mag_dy = r_a_dy[CB] ? DW'(-r_a_dy) : DW'(r_a_dy);
    end

    logic          r_b_valid;
    logic [NW-1:0] r_b_ny, r_b_nx;
    logic [DW-1:0] r_b_dy, r_b_dx;
    logic [SW-1:0] r_b_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_ny   <= mag_py;
        r_b_nx   <= mag_px;
        r_b_dy   <= mag_dx;
        r_b_dx   <= mag_dy;
        r_b_side <= {r_a_dec, r_a_hit, prod_y[NW-1] ^ r_a_dx[CB],
                     prod_x[NW-1] ^ r_a_dy[CB], r_a_x1, r_a_y1};
    end

    // divider chain: one cell per quotient bit
    logic          c_valid [0:NW];
    logic [DW-1:0] c_rem_y [0:NW];
    logic [NW-1:0] c_num_y [0:NW];
    logic [NW-1:0] c_quo_y [0:NW];
    logic [DW-1:0] c_den_y [0:NW];
    logic [DW-1:0] c_rem_x [0:NW];
    logic [NW-1:0] c_num_x [0:NW];
    logic [NW-1:0] c_quo_x [0:NW];
    logic [DW-1:0] c_den_x [0:NW];
    logic [SW-1:0] c_side  [0:NW];

    assign c_valid[0] = r_b_valid;
    assign c_rem_y[0] = '0;
    assign c_num_y[0] = r_b_ny;
    assign c_quo_y[0] = '0;
    assign c_den_y[0] = r_b_dy;
    assign c_rem_x[0] = '0;
    assign c_num_x[0] = r_b_nx;
    assign c_quo_x[0] = '0;
    assign c_den_x[0] = r_b_dx;
    assign c_side[0]  = r_b_side;

    for (genvar g = 0; g < NW; g++) begin : g_cell
        srht_cell #(
            .NW (NW),
            .DW (DW),
            .SW (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .i_rem_y (c_rem_y[g]),
            .i_num_y (c_num_y[g]),
            .i_quo_y (c_quo_y[g]),
            .i_den_y (c_den_y[g]),
            .i_rem_x (c_rem_x[g]),
            .i_num_x (c_num_x[g]),
            .i_quo_x (c_quo_x[g]),
            .i_den_x (c_den_x[g]),
            .i_side  (c_side[g]),
            .o_valid (c_valid[g+1]),
            .o_rem_y (c_rem_y[g+1]),
            .o_num_y (c_num_y[g+1]),
            .o_quo_y (c_quo_y[g+1]),
            .o_den_y (c_den_y[g+1]),
            .o_rem_x (c_rem_x[g+1]),
            .o_num_x (c_num_x[g+1]),
            .o_quo_x (c_quo_x[g+1]),
            .o_den_x (c_den_x[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    // output stage: apply quotient signs, form crossings, compare to the span
    logic                 f_dec, f_ehit, f_sy, f_sx, f_hit;
    logic signed [CB-1:0] f_x1, f_y1;
    logic signed [QW-1:0] qy, qx, yi, xi;

    always_comb begin
        {f_dec, f_ehit, f_sy, f_sx, f_x1, f_y1} = c_side[NW];
        qy = f_sy ? -$signed({2'b00, c_quo_y[NW]}) : $signed({2'b00, c_quo_y[NW]});
        qx = f_sx ? -$signed({2'b00, c_quo_x[NW]}) : $signed({2'b00, c_quo_x[NW]});
        yi = $signed({{(QW-CB){f_y1[CB-1]}}, f_y1}) + qy;
        xi = $signed({{(QW-CB){f_x1[CB-1]}}, f_x1}) + qx;
        f_hit = f_dec ? f_ehit
              : ((yi >= $signed({{(QW-CB-1){top_e[CB]}}, top_e}))
                 && (yi < $signed({{(QW-CB-1){bot_e[CB]}}, bot_e})))
             || ((xi >= $signed({{(QW-CB-1){left_e[CB]}}, left_e}))
                 && (xi < $signed({{(QW-CB-1){right_e[CB]}}, right_e})));
    end

    logic r_valid, r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= c_valid[NW];
            r_hit   <= c_valid[NW] && f_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

// ----- rtl/srht_cell.sv -----
// One quotient bit of both edge divisions, with the request's side data alongside.
module srht_cell #(
    parameter int unsigned NW = 35,
    parameter int unsigned DW = 17,
    parameter int unsigned SW = 36
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem_y,
    input  logic [NW-1:0] i_num_y,
    input  logic [NW-1:0] i_quo_y,
    input  logic [DW-1:0] i_den_y,
    input  logic [DW-1:0] i_rem_x,
    input  logic [NW-1:0] i_num_x,
    input  logic [NW-1:0] i_quo_x,
    input  logic [DW-1:0] i_den_x,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_rem_y,
    output logic [NW-1:0] o_num_y,
    output logic [NW-1:0] o_quo_y,
    output logic [DW-1:0] o_den_y,
    output logic [DW-1:0] o_rem_x,
    output logic [NW-1:0] o_num_x,
    output logic [NW-1:0] o_quo_x,
    output logic [DW-1:0] o_den_x,
    output logic [SW-1:0] o_side
);
    import srht_pkg::*;

    logic          r_valid;
    logic [DW-1:0] r_rem_y, r_den_y, r_rem_x, r_den_x;
    logic [NW-1:0] r_num_y, r_quo_y, r_num_x, r_quo_x;
    logic [SW-1:0] r_side;

    logic [DW:0]   trial_y, trial_x, diff_y, diff_x;
    logic          take_y, take_x;

    // bring down the next dividend bit and try to subtract the divisor
    always_comb begin
        trial_y = {i_rem_y, i_num_y[NW-1]};
        trial_x = {i_rem_x, i_num_x[NW-1]};
        diff_y  = trial_y - {1'b0, i_den_y};
        diff_x  = trial_x - {1'b0, i_den_x};
        take_y  = (trial_y >= {1'b0, i_den_y});
        take_x  = (trial_x >= {1'b0, i_den_x});
    end

    // clear only the valid flag under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // advance the partial remainder, dividend and quotient
    always_ff @(posedge i_clk) begin
        r_rem_y <= take_y ? diff_y[DW-1:0] : trial_y[DW-1:0];
        r_rem_x <= take_x ? diff_x[DW-1:0] : trial_x[DW-1:0];
        r_num_y <= {i_num_y[NW-2:0], 1'b0};
        r_num_x <= {i_num_x[NW-2:0], 1'b0};
        r_quo_y <= {i_quo_y[NW-2:0], take_y};
        r_quo_x <= {i_quo_x[NW-2:0], take_x};
        r_den_y <= i_den_y;
        r_den_x <= i_den_x;
        r_side  <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rem_y = r_rem_y;
    assign o_num_y = r_num_y;
    assign o_quo_y = r_quo_y;
    assign o_den_y = r_den_y;
    assign o_rem_x = r_rem_x;
    assign o_num_x = r_num_x;
    assign o_quo_x = r_quo_x;
    assign o_den_x = r_den_x;
    assign o_side  = r_side;

endmodule

// ----- rtl/srht_checker.sv -----
// Port-level checks for the hit test, bound to the top level.
module srht_checker #(
    parameter int unsigned COORD_BITS = srht_pkg::COORD_BITS_DEF
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid,
    input logic o_hit
);
    import srht_pkg::*;

    localparam int unsigned LAT = 2 * COORD_BITS + 6;

    // every accepted request yields a result after the fixed latency
    a_req_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LAT o_valid)
        else $error("result missing after accepted request");

    // no result without a request the fixed latency before
    a_res_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, LAT))
        else $error("result without matching request");

    // hit only flagged with a valid result
    a_hit_qual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_hit)
        else $error("hit outside a result cycle");

endmodule

bind segment_rect_hit_test srht_checker #(
    .COORD_BITS (COORD_BITS)
) u_srht_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid),
    .o_hit   (o_hit)
);
